>>> hdl/periodic_event_timer_scheduler_defines.svh
// Assertion macros for the periodic event timer scheduler.
`ifndef PERIODIC_EVENT_TIMER_SCHEDULER_DEFINES_SVH
`define PERIODIC_EVENT_TIMER_SCHEDULER_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define PETS_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define PETS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> hdl/pets_pkg.sv
// Shared constants, types and codes of the periodic event timer scheduler.
`default_nettype none
package pets_pkg;
  localparam int NumEvents  = 16;
  localparam int FifoDepth  = 32;
  localparam int TimeWidth  = 32;
  localparam int IdxW       = $clog2(NumEvents);
  localparam int FifoAw     = $clog2(FifoDepth);
  localparam int FillW      = $clog2(FifoDepth + 1);

  typedef logic [TimeWidth-1:0] time_t;
  typedef logic [IdxW-1:0]      idx_t;

  typedef enum logic [3:0] {
    MODE_CREATE  = 4'd0,  MODE_START  = 4'd1, MODE_STOP    = 4'd2,
    MODE_TICK    = 4'd3,  MODE_GET    = 4'd4, MODE_POST    = 4'd5,
    MODE_SETPRI  = 4'd6,  MODE_PERCLR = 4'd7, MODE_PERKEEP = 4'd8,
    MODE_RESTART = 4'd9,  MODE_SLEEP  = 4'd10, MODE_RESUME = 4'd11
  } mode_t;

  // FIFO request from the sequencer.
  typedef struct packed {
    logic       push;
    logic       pop;
    logic       clear;
    logic [7:0] push_id;
  } fifo_req_t;

  typedef struct packed {
    logic       full;
    logic       empty;
    logic [7:0] head_id;
  } fifo_stat_t;
endpackage
`default_nettype wire

>>> hdl/periodic_event_timer_scheduler.sv
// Top level of the periodic event timer scheduler: sequencer, table and FIFO.
//
// One command word enters on s_axis and one result word leaves on m_axis.
// Single-entry commands pass through the accept, execute and output states
// from one accepted word to the next. Tick, sleep, resume and get walk the
// entry table one entry per cycle through one shared add/compare unit,
// stopping early when the created entries end; a get then passes through
// ST_GETW and ST_GETF. The block takes no new word until the result of the
// current one has been taken. The FIFO read port is registered, so a get
// waits in ST_GETW after the walk before using the head id.
`default_nettype none
`include "periodic_event_timer_scheduler_defines.svh"
module periodic_event_timer_scheduler (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // [3:0] mode, [11:4] event number, [43:12] period_ticks, [48:44] priority_level
  input  wire  [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // [0] status, [8:1] got_event, [9] overflow
  output logic [15:0] m_axis_tdata
);
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001, ST_WALK = 5'b00010, ST_GETW = 5'b00100,
    ST_GETF = 5'b01000, ST_OUT  = 5'b10000
  } state_t;
  state_t state;

  // Table of entries; count and period are memories walked one per cycle.
  logic [pets_pkg::NumEvents-1:0] created, running, trig, saved;
  logic [4:0] prio [pets_pkg::NumEvents];
  pets_pkg::time_t cnt [pets_pkg::NumEvents];
  pets_pkg::time_t per [pets_pkg::NumEvents];

  logic [3:0]  mode;
  logic [7:0]  id;
  pets_pkg::time_t period;
  logic [4:0]  plev;
  logic [pets_pkg::IdxW:0] walk;
  pets_pkg::idx_t wi;
  logic [4:0]  best_pri;
  pets_pkg::idx_t best;
  logic        status, ovf;
  logic [7:0]  got;
  pets_pkg::fifo_req_t  freq;
  pets_pkg::fifo_stat_t fstat;

  logic valid_id;
  pets_pkg::idx_t idx;
  pets_pkg::time_t inc;
  logic fire;
  logic walk_end;

  assign valid_id = (id != 8'd0) && ({1'b0, id} <= 9'(pets_pkg::NumEvents));
  assign idx      = pets_pkg::IdxW'(id - 8'd1);
  assign wi       = walk[pets_pkg::IdxW-1:0];
  assign walk_end = (walk == (pets_pkg::IdxW+1)'(pets_pkg::NumEvents)) || !created[wi];
  // Shared unit: increment and compare for the walked entry.
  assign inc  = cnt[wi] + 1'b1;
  assign fire = (inc >= per[wi]);

  pets_fifo u_fifo (.clk(clk), .rst(rst), .req(freq), .stat(fstat));

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tdata  = {6'd0, ovf, got, status};

  // FIFO requests: push on a firing or posted priority-0 entry, pop on get, clear on sleep.
  always_comb begin
    freq = '0;
    if (state == ST_WALK && !walk_end && mode == pets_pkg::MODE_TICK &&
        running[wi] && fire && prio[wi] == 5'd0) begin
      freq.push = 1'b1; freq.push_id = 8'(walk) + 8'd1;
    end
    if (state == ST_IDLE && s_axis_tvalid && s_axis_tdata[3:0] == pets_pkg::MODE_POST &&
        s_axis_tdata[11:4] != 8'd0 &&
        {1'b0, s_axis_tdata[11:4]} <= 9'(pets_pkg::NumEvents)) begin
      // post handled after capture
    end
    if (state == ST_WALK && mode == pets_pkg::MODE_POST && valid_id && prio[idx] == 5'd0) begin
      freq.push = 1'b1; freq.push_id = id;
    end
    if (state == ST_GETF && best_pri == 5'd0) freq.pop = 1'b1;
    if (state == ST_WALK && walk_end && mode == pets_pkg::MODE_SLEEP) freq.clear = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      created <= '0; running <= '0; trig <= '0; saved <= '0;
      for (int k = 0; k < pets_pkg::NumEvents; k++) prio[k] <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            mode <= s_axis_tdata[3:0]; id <= s_axis_tdata[11:4];
            period <= s_axis_tdata[43:12]; plev <= s_axis_tdata[48:44];
            walk <= '0; best_pri <= '0; best <= '0;
            status <= 1'b0; ovf <= 1'b0; got <= '0;
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          unique case (mode)
            pets_pkg::MODE_TICK, pets_pkg::MODE_GET,
            pets_pkg::MODE_SLEEP, pets_pkg::MODE_RESUME: begin
              if (walk_end) begin
                state <= (mode == pets_pkg::MODE_GET) ? ST_GETW : ST_OUT;
              end else begin
                walk <= walk + 1'b1;
                if (mode == pets_pkg::MODE_TICK && running[wi]) begin
                  if (fire) begin
                    if (prio[wi] == 5'd0) begin
                      if (fstat.full) ovf <= 1'b1;
                    end else trig[wi] <= 1'b1;
                  end
                end
                if (mode == pets_pkg::MODE_GET && trig[wi] && prio[wi] > best_pri) begin
                  best_pri <= prio[wi]; best <= wi;
                end
                if (mode == pets_pkg::MODE_SLEEP) begin
                  trig[wi] <= 1'b0; saved[wi] <= running[wi]; running[wi] <= 1'b0;
                end
                if (mode == pets_pkg::MODE_RESUME) begin
                  running[wi] <= saved[wi]; saved[wi] <= 1'b0;
                end
              end
            end
            default: begin
              state <= ST_OUT;
              if (mode <= pets_pkg::MODE_RESTART) begin
                if (!valid_id) status <= 1'b1;
                else begin
                  unique case (mode)
                    pets_pkg::MODE_CREATE: begin
                      if ((created & ((pets_pkg::NumEvents)'(1) << idx) - 1'b1) !=
                          ((pets_pkg::NumEvents)'(1) << idx) - 1'b1) status <= 1'b1;
                      else begin
                        created[idx] <= 1'b1; prio[idx] <= '0;
                      end
                    end
                    pets_pkg::MODE_START:   running[idx] <= 1'b1;
                    pets_pkg::MODE_STOP:    running[idx] <= 1'b0;
                    pets_pkg::MODE_POST: begin
                      if (prio[idx] != 5'd0) trig[idx] <= 1'b1;
                      else if (fstat.full) ovf <= 1'b1;
                    end
                    pets_pkg::MODE_SETPRI:  prio[idx] <= plev;
                    pets_pkg::MODE_RESTART: running[idx] <= 1'b1;
                    default: ;
                  endcase
                end
              end
            end
          endcase
        end
        ST_GETW: state <= ST_GETF;
        ST_GETF: begin
          if (best_pri != 5'd0) begin
            trig[best] <= 1'b0; got <= 8'(best) + 8'd1;
          end else if (!fstat.empty) got <= fstat.head_id;
          state <= ST_OUT;
        end
        ST_OUT: if (m_axis_tready) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Count and period memories, written in the walk state.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < pets_pkg::NumEvents; k++) begin
        cnt[k] <= '0; per[k] <= '0;
      end
    end else if (state == ST_WALK) begin
      if (!walk_end && mode == pets_pkg::MODE_TICK && running[wi])
        cnt[wi] <= fire ? '0 : inc;
      else if (!walk_end && mode == pets_pkg::MODE_SLEEP)
        cnt[wi] <= '0;
      else if (valid_id) begin
        unique case (mode)
          pets_pkg::MODE_CREATE: if ((created & ((pets_pkg::NumEvents)'(1) << idx) - 1'b1) ==
                                     ((pets_pkg::NumEvents)'(1) << idx) - 1'b1)
                                   per[idx] <= period;
          pets_pkg::MODE_STOP, pets_pkg::MODE_RESTART: cnt[idx] <= '0;
          pets_pkg::MODE_PERCLR: begin cnt[idx] <= '0; per[idx] <= period; end
          pets_pkg::MODE_PERKEEP: per[idx] <= period;
          default: ;
        endcase
      end
    end
  end

  `PETS_ASSERT(a_ready_only_idle, s_axis_tready, !m_axis_tvalid)
  `PETS_ASSERT(a_got_only_get, m_axis_tvalid && mode != pets_pkg::MODE_GET, got == 8'd0)
  `PETS_ASSERT_NEXT(a_out_held, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
endmodule
`default_nettype wire

>>> hdl/pets_fifo.sv
// Event id FIFO with a registered-read memory.
`default_nettype none
`include "periodic_event_timer_scheduler_defines.svh"
module pets_fifo (
  input  wire                  clk,
  input  wire                  rst,
  input  pets_pkg::fifo_req_t  req,
  output pets_pkg::fifo_stat_t stat
);
  logic [7:0] mem [pets_pkg::FifoDepth];
  logic [pets_pkg::FifoAw-1:0] head, tail;
  logic [pets_pkg::FillW-1:0]  fill;
  logic [7:0] rd_data;

  always_ff @(posedge clk) begin
    if (req.push && !stat.full) mem[tail] <= req.push_id;
    rd_data <= mem[head];
  end

  always_ff @(posedge clk) begin
    if (rst || req.clear) begin
      head <= '0; tail <= '0; fill <= '0;
    end else begin
      if (req.push && !stat.full) tail <= tail + 1'b1;
      if (req.pop && !stat.empty) head <= head + 1'b1;
      if (req.push && !stat.full && !(req.pop && !stat.empty)) fill <= fill + 1'b1;
      else if (!(req.push && !stat.full) && req.pop && !stat.empty) fill <= fill - 1'b1;
    end
  end

  assign stat.full    = (fill == pets_pkg::FillW'(pets_pkg::FifoDepth));
  assign stat.empty   = (fill == '0);
  assign stat.head_id = rd_data;

  `PETS_ASSERT(a_fill_range, 1'b1, fill <= pets_pkg::FillW'(pets_pkg::FifoDepth))
  `PETS_ASSERT_NEXT(a_clear_empties, req.clear, fill == '0)
  `PETS_ASSERT(a_no_pushpop_same, req.push, !req.pop)
endmodule
`default_nettype wire

>>> tb/sv/periodic_event_timer_scheduler_tb.sv
// Testbench for the periodic event timer scheduler: directed and random command words.
`timescale 1ns / 100ps
`default_nettype none
module periodic_event_timer_scheduler_tb;

  typedef struct packed {
    logic       status;
    logic [7:0] got;
    logic       ovf;
  } sched_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  periodic_event_timer_scheduler u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #2 clk = ~clk;

  // Shadow of the scheduler state.
  logic              sh_created [pets_pkg::NumEvents];
  pets_pkg::time_t   sh_count   [pets_pkg::NumEvents];
  pets_pkg::time_t   sh_period  [pets_pkg::NumEvents];
  logic [4:0]        sh_prio    [pets_pkg::NumEvents];
  logic              sh_run     [pets_pkg::NumEvents];
  logic              sh_trig    [pets_pkg::NumEvents];
  logic              sh_saved   [pets_pkg::NumEvents];
  logic [7:0]        sh_fifo    [$];

  logic [55:0]  pending_words [$];
  sched_res_t   expected_results [$];
  int           errors = 0;
  bit           hold_for_drain = 0;
  int           stall_long = 0;

  function automatic logic [55:0] pack_cmd(logic [3:0] m, logic [7:0] id, logic [31:0] per,
                                           logic [4:0] pr);
    return {7'd0, pr, per, id, m};
  endfunction

  function automatic logic fire(int i);
    if (sh_prio[i] == 0) begin
      if (sh_fifo.size() >= pets_pkg::FifoDepth) return 1'b1;
      sh_fifo.push_back(8'(i + 1));
      return 1'b0;
    end
    sh_trig[i] = 1'b1;
    return 1'b0;
  endfunction

  // Apply one command to the shadow and return the result word it must give.
  function automatic sched_res_t schedule_step(logic [55:0] w);
    sched_res_t r;
    logic [3:0] m;
    logic [7:0] id;
    pets_pkg::time_t per;
    logic [4:0] pr;
    bit         ok;
    int         x;
    int         best;
    logic [4:0] bp;
    m = w[3:0]; id = w[11:4]; per = w[43:12]; pr = w[48:44];
    r = '0;
    ok = (id != 0) && (id <= pets_pkg::NumEvents);
    x = ok ? id - 1 : 0;
    if (!ok && (m inside {pets_pkg::MODE_CREATE, pets_pkg::MODE_START, pets_pkg::MODE_STOP,
                          pets_pkg::MODE_POST, pets_pkg::MODE_SETPRI, pets_pkg::MODE_PERCLR,
                          pets_pkg::MODE_PERKEEP, pets_pkg::MODE_RESTART})) begin
      r.status = 1'b1;
      return r;
    end
    case (m)
      pets_pkg::MODE_CREATE: begin
        for (int i = 0; i < x; i++) if (!sh_created[i]) r.status = 1'b1;
        if (!r.status) begin
          sh_created[x] = 1'b1; sh_period[x] = per; sh_prio[x] = '0;
        end
      end
      pets_pkg::MODE_START: sh_run[x] = 1'b1;
      pets_pkg::MODE_STOP: begin sh_run[x] = 1'b0; sh_count[x] = '0; end
      pets_pkg::MODE_TICK: begin
        for (int i = 0; i < pets_pkg::NumEvents && sh_created[i]; i++) begin
          if (sh_run[i]) begin
            sh_count[i] = sh_count[i] + 1;
            if (sh_count[i] >= sh_period[i]) begin
              sh_count[i] = '0;
              if (fire(i)) r.ovf = 1'b1;
            end
          end
        end
      end
      pets_pkg::MODE_GET: begin
        best = 0; bp = '0;
        for (int i = 0; i < pets_pkg::NumEvents && sh_created[i]; i++)
          if (sh_trig[i] && sh_prio[i] > bp) begin bp = sh_prio[i]; best = i; end
        if (bp != 0) begin
          sh_trig[best] = 1'b0; r.got = 8'(best + 1);
        end else if (sh_fifo.size() > 0) begin
          r.got = sh_fifo.pop_front();
        end
      end
      pets_pkg::MODE_POST: if (fire(x)) r.ovf = 1'b1;
      pets_pkg::MODE_SETPRI: sh_prio[x] = pr;
      pets_pkg::MODE_PERCLR: begin sh_count[x] = '0; sh_period[x] = per; end
      pets_pkg::MODE_PERKEEP: sh_period[x] = per;
      pets_pkg::MODE_RESTART: begin sh_count[x] = '0; sh_run[x] = 1'b1; end
      pets_pkg::MODE_SLEEP: begin
        sh_fifo.delete();
        for (int i = 0; i < pets_pkg::NumEvents && sh_created[i]; i++) begin
          sh_count[i] = '0; sh_trig[i] = 1'b0;
          sh_saved[i] = sh_run[i]; sh_run[i] = 1'b0;
        end
      end
      pets_pkg::MODE_RESUME: begin
        for (int i = 0; i < pets_pkg::NumEvents && sh_created[i]; i++) begin
          sh_run[i] = sh_saved[i]; sh_saved[i] = 1'b0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int got_v, int exp_v);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got_v, exp_v, $realtime);
    errors++;
  endtask

  // Driver: bursts of words with random gaps; hold off while a drain is asked.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(schedule_step(s_axis_tdata));
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        // Previous word taken or none offered: pick what to show next.
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_words.size() > 0 && !hold_for_drain) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_words.pop_front();
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 20);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern, plus a long hold-off on request.
  int ready_phase = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (stall_long > 0) begin
      stall_long    <= stall_long - 1;
      m_axis_tready <= 1'b0;
    end else begin
      ready_phase <= ready_phase + 1;
      case ((ready_phase / 64) % 3)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        default: m_axis_tready <= ($urandom_range(0, 1) == 1);
      endcase
    end
  end

  // Monitor: compare each result word with the oldest expectation.
  sched_res_t exp_r;
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected word", m_axis_tdata, 0);
      end else begin
        exp_r = expected_results.pop_front();
        if (m_axis_tdata[0] !== exp_r.status)
          report_mismatch("status", m_axis_tdata[0], exp_r.status);
        if (m_axis_tdata[8:1] !== exp_r.got)
          report_mismatch("got_event", m_axis_tdata[8:1], exp_r.got);
        if (m_axis_tdata[9] !== exp_r.ovf)
          report_mismatch("overflow", m_axis_tdata[9], exp_r.ovf);
      end
    end
  end

  function automatic logic [31:0] rand_period();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  function automatic logic [7:0] rand_id();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return $urandom_range(17, 255);
      2: return 8'd255;
      default: return $urandom_range(1, pets_pkg::NumEvents);
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_words.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    logic [3:0] m;
    int n;
    for (int i = 0; i < pets_pkg::NumEvents; i++) begin
      sh_created[i] = 0; sh_count[i] = 0; sh_period[i] = 0; sh_prio[i] = 0;
      sh_run[i] = 0; sh_trig[i] = 0; sh_saved[i] = 0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: order checks, invalid ids, zero period, wrap, priorities.
    pending_words.push_back(pack_cmd(pets_pkg::MODE_CREATE, 8'd2, 32'd1, 5'd0));   // order broken
    pending_words.push_back(pack_cmd(pets_pkg::MODE_CREATE, 8'd0, 32'd1, 5'd0));   // id zero
    pending_words.push_back(pack_cmd(pets_pkg::MODE_CREATE, 8'd1, 32'd0, 5'd0));   // zero period
    pending_words.push_back(pack_cmd(pets_pkg::MODE_CREATE, 8'd2, 32'hFFFF_FFFF, 5'd31));
    pending_words.push_back(pack_cmd(pets_pkg::MODE_CREATE, 8'd3, 32'd2, 5'd0));
    pending_words.push_back(pack_cmd(pets_pkg::MODE_CREATE, 8'd1, 32'd0, 5'd0));   // re-create
    pending_words.push_back(pack_cmd(pets_pkg::MODE_START, 8'd1, 32'd0, 5'd0));
    pending_words.push_back(pack_cmd(pets_pkg::MODE_START, 8'd17, 32'd0, 5'd0));
    pending_words.push_back(pack_cmd(pets_pkg::MODE_PERKEEP, 8'd3, 32'd1, 5'd0));
    pending_words.push_back(pack_cmd(pets_pkg::MODE_RESTART, 8'd3, 32'd0, 5'd0));
    pending_words.push_back(pack_cmd(pets_pkg::MODE_TICK, 8'd255, 32'd0, 5'd0));
    pending_words.push_back(pack_cmd(pets_pkg::MODE_SETPRI, 8'd3, 32'd0, 5'd31));
    pending_words.push_back(pack_cmd(pets_pkg::MODE_POST, 8'd3, 32'd0, 5'd0));    // raises trigger
    pending_words.push_back(pack_cmd(pets_pkg::MODE_SETPRI, 8'd3, 32'd0, 5'd0));  // lowered
    pending_words.push_back(pack_cmd(pets_pkg::MODE_GET, 8'd0, 32'd0, 5'd0));
    pending_words.push_back(pack_cmd(pets_pkg::MODE_GET, 8'd0, 32'd0, 5'd0));
    pending_words.push_back(pack_cmd(pets_pkg::MODE_POST, 8'd16, 32'd0, 5'd0));   // uncreated
    pending_words.push_back(pack_cmd(pets_pkg::MODE_PERCLR, 8'd2, 32'hFFFF_FFFF, 5'd0));
    pending_words.push_back(pack_cmd(pets_pkg::MODE_STOP, 8'd1, 32'd0, 5'd0));
    pending_words.push_back(pack_cmd(pets_pkg::MODE_SLEEP, 8'd0, 32'd0, 5'd0));
    pending_words.push_back(pack_cmd(pets_pkg::MODE_GET, 8'd0, 32'd0, 5'd0));
    pending_words.push_back(pack_cmd(pets_pkg::MODE_RESUME, 8'd0, 32'd0, 5'd0));
    pending_words.push_back(pack_cmd(4'd12, 8'd1, 32'd0, 5'd0));
    pending_words.push_back(pack_cmd(4'd15, 8'hAA, 32'h5555_5555, 5'h15));
    for (int k = 0; k < 40; k++)                                        // overflow the FIFO
      pending_words.push_back(pack_cmd(pets_pkg::MODE_POST, 8'd1, 32'd0, 5'd0));
    pending_words.push_back(pack_cmd(pets_pkg::MODE_TICK, 8'd0, 32'd0, 5'd0));
    wait_drained();

    // Long receiver hold-off while words keep coming.
    for (int k = 0; k < 20; k++)
      pending_words.push_back(pack_cmd(pets_pkg::MODE_POST, rand_id(), 32'd0, 5'd0));
    stall_long = 300;
    wait_drained();

    // Random part: mostly created, running entries with ticks and gets.
    for (int k = 0; k < 1050; k++) begin
      n = $urandom_range(0, 99);
      if (n < 25) m = pets_pkg::MODE_TICK;
      else if (n < 45) m = pets_pkg::MODE_GET;
      else if (n < 52) m = pets_pkg::MODE_CREATE;
      else if (n < 58) m = pets_pkg::MODE_START;
      else if (n < 62) m = pets_pkg::MODE_STOP;
      else if (n < 70) m = pets_pkg::MODE_POST;
      else if (n < 77) m = pets_pkg::MODE_SETPRI;
      else if (n < 81) m = pets_pkg::MODE_PERCLR;
      else if (n < 85) m = pets_pkg::MODE_PERKEEP;
      else if (n < 91) m = pets_pkg::MODE_RESTART;
      else if (n < 94) m = pets_pkg::MODE_SLEEP;
      else if (n < 97) m = pets_pkg::MODE_RESUME;
      else m = 4'($urandom_range(0, 15));
      pending_words.push_back(pack_cmd(m, rand_id(), rand_period(),
                                       ($urandom_range(0, 2) == 0) ? 5'd0 : 5'($urandom)));
      if (k == 500) begin
        // Pause the sender until every result is home.
        wait_drained();
      end
    end
    wait_drained();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end
endmodule
`default_nettype wire
